// File: rtl/core/smro_pkg.sv
// ============================================================================
// smro_pkg: shared definitions of the sliding mode rotor angle observer
// Formats, widths, register indexes, helper functions and the arctangent
// table that the core and its serial multiplier use.
// ============================================================================
package smro_pkg;

    localparam int SIGNAL_BITS  = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int FIELD_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int LIM_W     = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int IN_W      = 4 * FIELD_W;
    localparam int OUT_W     = 3 * FIELD_W;

    localparam int SIG_W     = SIGNAL_BITS;
    localparam int PROD_W    = SIG_W + GAIN_W + 2;
    localparam int WIDE_W    = PROD_W + 4;
    localparam int CNT_W     = $clog2(GAIN_W);
    localparam int CORD_W    = SIG_W + 11;
    localparam int ANG_W     = 34;
    localparam int STEP_W    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int TAB_IDX_W = 5;

    localparam int FRAC_BITS    = 12;
    localparam int ROUND_HALF   = 2 ** (FRAC_BITS - 1);
    localparam int PRE_SHIFT    = 8;
    localparam int QUARTER_TURN = 2 ** 30;
    localparam int ANG_ROUND    = 2 ** 15;

    localparam int LIM_RST  = 2048;
    localparam int GAIN_RST = 41;

    typedef logic signed [SIG_W-1:0]  t_sig;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [GAIN_W-1:0]        t_gain;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY = 3'd0,
        CFG_INPUT = 3'd1,
        CFG_LIMIT = 3'd2,
        CFG_SLIDE = 3'd3,
        CFG_EMF   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic  start;
        t_gain gain;
        t_sig  opnd;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

    function automatic t_sig f_sat(input t_wide v);
        t_wide v_max;
        t_wide v_min;
        v_max = t_wide'({1'b0, {(SIG_W-1){1'b1}}});
        v_min = ~v_max;
        if (v > v_max) begin
            return t_sig'(v_max);
        end else if (v < v_min) begin
            return t_sig'(v_min);
        end
        return t_sig'(v);
    endfunction

    function automatic t_wide f_rnd12(input t_wide v);
        return (v + t_wide'(ROUND_HALF)) >>> FRAC_BITS;
    endfunction

    // Arctangent of 2^-i with pi scaled to 2^31.
    function automatic logic [31:0] f_atan(input logic [TAB_IDX_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/smro_serial_mul.sv
// ============================================================================
// smro_serial_mul: bit-serial gain multiplier
// Multiplies an unsigned Q4.12 gain by a signed signal, one gain bit per
// cycle, shifting the finished low product bits out to the right.
// ============================================================================
module smro_serial_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smro_pkg::t_mul_req i_req,
    output smro_pkg::t_mul_rsp o_rsp
);
    import smro_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    t_gain                   r_gain;
    t_sig                    r_opnd;
    logic signed [SIG_W+1:0] r_hi;
    logic [GAIN_W-1:0]       r_lo;
    logic signed [SIG_W+1:0] w_addend;
    logic signed [SIG_W+1:0] w_sum;

    assign w_addend = r_gain[0] ? (SIG_W+2)'(r_opnd) : '0;
    assign w_sum    = r_hi + w_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_gain <= i_req.gain;
            r_opnd <= i_req.opnd;
            r_hi   <= '0;
            r_lo   <= '0;
        end else if (r_busy) begin
            r_hi   <= w_sum >>> 1;
            r_lo   <= {w_sum[0], r_lo[GAIN_W-1:1]};
            r_gain <= r_gain >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi, r_lo};

endmodule

// File: rtl/core/sliding_mode_rotor_angle_observer_core.sv
// ============================================================================
// sliding_mode_rotor_angle_observer_core: sliding mode rotor angle observer
// Per sample it updates the current model, the sliding correction and the
// back EMF of both axes, then finds the rotor angle with a vectoring CORDIC.
// ============================================================================
// One word in gives one word out. The single bit-serial multiplier forms
// eight gain products per word, with the glue states S_DIFF, S_ERR and
// S_FILT on each axis. The CORDIC then sets up and runs its micro-rotations
// one after another, and the result is then loaded into the output register.
// The input is ready again as soon as the result moves to the output
// register, so a new word is worked on while the last result waits to be
// taken; no new word is accepted before the last result has moved there.
module sliding_mode_rotor_angle_observer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // volt_alpha, volt_beta, curr_alpha, curr_beta (16 bits each)
    input  logic [smro_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // rotor_angle, emf_alpha, emf_beta (16 bits each)
    output logic [smro_pkg::OUT_W-1:0]     o_m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [smro_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [smro_pkg::CFG_W-1:0]     i_cfg_data
);
    import smro_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DIFF  = 11'b000_0000_0010,
        S_MUL_F = 11'b000_0000_0100,
        S_MUL_G = 11'b000_0000_1000,
        S_ERR   = 11'b000_0001_0000,
        S_MUL_K = 11'b000_0010_0000,
        S_FILT  = 11'b000_0100_0000,
        S_MUL_E = 11'b000_1000_0000,
        S_CINIT = 11'b001_0000_0000,
        S_CORD  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic                     r_axis;
    t_sig                     r_volt [2];
    t_sig                     r_curr [2];
    t_sig                     r_est [2];
    t_sig                     r_slide [2];
    t_sig                     r_emf [2];
    t_sig                     r_d;
    logic signed [PROD_W-1:0] r_acc;
    t_gain                    r_decay;
    t_gain                    r_igain;
    logic [LIM_W-1:0]         r_lim;
    t_gain                    r_kslide;
    t_gain                    r_kemf;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [ANG_W-1:0]  r_z;
    logic [STEP_W-1:0]        r_step;
    logic                     r_zero;
    logic                     r_ovalid;
    logic [OUT_W-1:0]         r_odata;

    t_mul_req                 w_req;
    t_mul_rsp                 w_rsp;
    t_sig                     w_d;
    t_sig                     w_est_new;
    t_sig                     w_err_raw;
    t_wide                    w_lim;
    t_sig                     w_err;
    t_sig                     w_slide_new;
    t_sig                     w_fdiff;
    t_sig                     w_emf_new;
    logic signed [CORD_W-1:0] w_cx0;
    logic signed [CORD_W-1:0] w_cy0;
    logic signed [CORD_W-1:0] w_dx;
    logic signed [CORD_W-1:0] w_dy;
    logic signed [ANG_W-1:0]  w_atan;
    logic signed [ANG_W-1:0]  w_ang_sum;
    logic                     w_accept;
    logic                     w_load;

    smro_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_DONE) && (!r_ovalid || i_m_axis_tready);

    assign w_d = f_sat(t_wide'(r_volt[r_axis]) - t_wide'(r_emf[r_axis])
                       - t_wide'(r_slide[r_axis]));
    assign w_est_new   = f_sat(f_rnd12(t_wide'(r_acc) + t_wide'(w_rsp.prod)));
    assign w_err_raw   = f_sat(t_wide'(r_est[r_axis]) - t_wide'(r_curr[r_axis]));
    assign w_lim       = t_wide'({1'b0, r_lim});
    assign w_slide_new = f_sat(f_rnd12(t_wide'(w_rsp.prod) <<< 1));
    assign w_fdiff     = f_sat(t_wide'(r_slide[r_axis]) - t_wide'(r_emf[r_axis]));
    assign w_emf_new   = f_sat(t_wide'(r_emf[r_axis]) + f_rnd12(t_wide'(w_rsp.prod)));

    always_comb begin
        if (t_wide'(w_err_raw) >= w_lim) begin
            w_err = t_sig'(w_lim);
        end else if (t_wide'(w_err_raw) <= -w_lim) begin
            w_err = t_sig'(-w_lim);
        end else begin
            w_err = w_err_raw;
        end
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.gain  = r_decay;
        w_req.opnd  = r_est[r_axis];
        unique case (r_state)
            S_DIFF: begin
                w_req.start = 1'b1;
            end
            S_MUL_F: begin
                w_req.start = w_rsp.done;
                w_req.gain  = r_igain;
                w_req.opnd  = r_d;
            end
            S_ERR: begin
                w_req.start = 1'b1;
                w_req.gain  = r_kslide;
                w_req.opnd  = w_err;
            end
            S_FILT: begin
                w_req.start = 1'b1;
                w_req.gain  = r_kemf;
                w_req.opnd  = w_fdiff;
            end
            default: begin
            end
        endcase
    end

    assign w_cx0     = CORD_W'(r_emf[1]) <<< PRE_SHIFT;
    assign w_cy0     = -(CORD_W'(r_emf[0]) <<< PRE_SHIFT);
    assign w_dx      = r_y >>> r_step;
    assign w_dy      = r_x >>> r_step;
    assign w_atan    = ANG_W'(f_atan(TAB_IDX_W'(r_step)));
    assign w_ang_sum = r_z + ANG_W'(ANG_ROUND);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL_F;
            S_MUL_F: if (w_rsp.done) n_state = S_MUL_G;
            S_MUL_G: if (w_rsp.done) n_state = S_ERR;
            S_ERR:   n_state = S_MUL_K;
            S_MUL_K: if (w_rsp.done) n_state = S_FILT;
            S_FILT:  n_state = S_MUL_E;
            S_MUL_E: if (w_rsp.done) n_state = r_axis ? S_CINIT : S_DIFF;
            S_CINIT: n_state = S_CORD;
            S_CORD:  if (r_step == STEP_W'(CORDIC_STEPS - 1)) n_state = S_DONE;
            S_DONE:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_axis     <= 1'b0;
            r_est[0]   <= '0;
            r_est[1]   <= '0;
            r_slide[0] <= '0;
            r_slide[1] <= '0;
            r_emf[0]   <= '0;
            r_emf[1]   <= '0;
            r_decay    <= '0;
            r_igain    <= '0;
            r_lim      <= LIM_W'(LIM_RST);
            r_kslide   <= GAIN_W'(GAIN_RST);
            r_kemf     <= GAIN_W'(GAIN_RST);
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= w_load || (r_ovalid && !i_m_axis_tready);

            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DECAY: r_decay  <= i_cfg_data;
                    CFG_INPUT: r_igain  <= i_cfg_data;
                    CFG_LIMIT: r_lim    <= i_cfg_data[LIM_W-1:0];
                    CFG_SLIDE: r_kslide <= i_cfg_data;
                    CFG_EMF:   r_kemf   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_axis    <= 1'b0;
                        r_volt[0] <= f_sat(t_wide'(signed'(i_s_axis_tdata[15:0])));
                        r_volt[1] <= f_sat(t_wide'(signed'(i_s_axis_tdata[31:16])));
                        r_curr[0] <= f_sat(t_wide'(signed'(i_s_axis_tdata[47:32])));
                        r_curr[1] <= f_sat(t_wide'(signed'(i_s_axis_tdata[63:48])));
                    end
                end
                S_DIFF: begin
                    r_d <= w_d;
                end
                S_MUL_F: begin
                    if (w_rsp.done) r_acc <= w_rsp.prod;
                end
                S_MUL_G: begin
                    if (w_rsp.done) r_est[r_axis] <= w_est_new;
                end
                S_MUL_K: begin
                    if (w_rsp.done) r_slide[r_axis] <= w_slide_new;
                end
                S_MUL_E: begin
                    if (w_rsp.done) begin
                        r_emf[r_axis] <= w_emf_new;
                        r_axis        <= ~r_axis;
                    end
                end
                S_CINIT: begin
                    r_step <= '0;
                    r_zero <= (r_emf[0] == '0) && (r_emf[1] == '0);
                    if (w_cx0 < 0) begin
                        if (w_cy0 >= 0) begin
                            r_x <= w_cy0;
                            r_y <= -w_cx0;
                            r_z <= ANG_W'(QUARTER_TURN);
                        end else begin
                            r_x <= -w_cy0;
                            r_y <= w_cx0;
                            r_z <= -ANG_W'(QUARTER_TURN);
                        end
                    end else begin
                        r_x <= w_cx0;
                        r_y <= w_cy0;
                        r_z <= '0;
                    end
                end
                S_CORD: begin
                    r_step <= r_step + 1'b1;
                    if (r_y >= 0) begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_atan;
                    end else begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_atan;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_odata <= {FIELD_W'(r_emf[1]), FIELD_W'(r_emf[0]),
                                    r_zero ? FIELD_W'(0) : w_ang_sum[31:16]};
                    end
                end
                S_ERR, S_FILT: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_cfg_ready     = 1'b1;

endmodule

// File: rtl/core/smro_checker.sv
// ============================================================================
// smro_checker: port-level checks of the rotor angle observer core
// Watches the stream handshakes and the count of words in flight.
// ============================================================================
module smro_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [smro_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import smro_pkg::*;

    logic [1:0] r_cnt;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_axis_tready)
        else $error("input ready while a word is being worked on");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_cnt != 2'd0)
        else $error("output word without an input word");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("more than two words in flight");

endmodule

bind sliding_mode_rotor_angle_observer_core smro_checker u_smro_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: tb/sv/tb_sliding_mode_rotor_angle_observer_core.sv
// ============================================================================
// tb_sliding_mode_rotor_angle_observer_core: observer core testbench
// Streams stator samples through the core and predicts each output word
// (rotor angle and back EMF of both axes) with an independent fixed-point
// model of the observer and its CORDIC. Directed tests cover reset values,
// register extremes, zero gains, ignored register indexes and every angle
// quadrant. Random phases then follow with plausible and arbitrary settings,
// most of them under random input gaps and output stalls.
// ============================================================================
module tb_sliding_mode_rotor_angle_observer_core;
    import smro_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [FIELD_W-1:0] curr_beta;
        logic signed [FIELD_W-1:0] curr_alpha;
        logic signed [FIELD_W-1:0] volt_beta;
        logic signed [FIELD_W-1:0] volt_alpha;
    } stator_sample_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] emf_beta;
        logic signed [FIELD_W-1:0] emf_alpha;
        logic signed [FIELD_W-1:0] rotor_angle;
    } observer_word_t;

    localparam longint SIG_HI = (longint'(1) << (SIGNAL_BITS - 1)) - 1;
    localparam longint SIG_LO = -SIG_HI - 1;
    localparam int AXIS_ALPHA = 0;
    localparam int AXIS_BETA  = 1;
    localparam int FIRST_SPARE_IDX = CFG_EMF + 1;
    localparam int DRAIN_CYCLES = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    sliding_mode_rotor_angle_observer_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow registers and observer state.
    longint decay_gain = 0;
    longint input_gain = 0;
    longint err_limit  = LIM_RST;
    longint slide_k    = GAIN_RST;
    longint filter_k   = GAIN_RST;
    longint est_curr [2] = '{0, 0};
    longint slide_corr [2] = '{0, 0};
    longint emf_est [2] = '{0, 0};

    longint atan_lut [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    observer_word_t expected_words [$];
    observer_word_t got_word;
    int             mismatch_count = 0;
    bit             gaps_on = 1'b1;
    bit             stalls_on = 1'b1;
    int             sink_hold = 0;
    stator_sample_t walk;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint clamp_sig(input longint v);
        return (v > SIG_HI) ? SIG_HI : ((v < SIG_LO) ? SIG_LO : v);
    endfunction

    function automatic longint q12_round(input longint p);
        return (p + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    function automatic void advance_axis(input int ax, input longint volt, input longint curr);
        longint drive;
        longint err;
        drive = clamp_sig(volt - emf_est[ax] - slide_corr[ax]);
        est_curr[ax] = clamp_sig(q12_round(decay_gain * est_curr[ax] + input_gain * drive));
        err = clamp_sig(est_curr[ax] - curr);
        if (err >= err_limit) begin
            err = err_limit;
        end else if (err <= -err_limit) begin
            err = -err_limit;
        end
        slide_corr[ax] = clamp_sig(q12_round(2 * err * slide_k));
        emf_est[ax] = clamp_sig(emf_est[ax]
                                + q12_round(filter_k * clamp_sig(slide_corr[ax] - emf_est[ax])));
    endfunction

    function automatic logic [FIELD_W-1:0] emf_to_angle(input longint ey, input longint ex);
        longint x;
        longint y;
        longint z;
        longint t;
        longint a;
        longint dx;
        longint dy;
        if (ex == 0 && ey == 0) begin
            return '0;
        end
        x = ex * (longint'(1) << PRE_SHIFT);
        y = ey * (longint'(1) << PRE_SHIFT);
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end else begin
                x = -y;
                y = t;
                z = -longint'(QUARTER_TURN);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            a = (i < 24) ? atan_lut[i] : 0;
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + a;
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - a;
            end
        end
        return FIELD_W'((z + ANG_ROUND) >>> 16);
    endfunction

    function automatic observer_word_t predict_observer_word(input stator_sample_t s);
        observer_word_t w;
        advance_axis(AXIS_ALPHA, clamp_sig(longint'(s.volt_alpha)),
                     clamp_sig(longint'(s.curr_alpha)));
        advance_axis(AXIS_BETA, clamp_sig(longint'(s.volt_beta)),
                     clamp_sig(longint'(s.curr_beta)));
        w.rotor_angle = emf_to_angle(-emf_est[AXIS_ALPHA], emf_est[AXIS_BETA]);
        w.emf_alpha   = FIELD_W'(emf_est[AXIS_ALPHA]);
        w.emf_beta    = FIELD_W'(emf_est[AXIS_BETA]);
        return w;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
    endfunction

    function automatic stator_sample_t make_sample(input logic [15:0] va, input logic [15:0] vb,
                                                   input logic [15:0] ia, input logic [15:0] ib);
        stator_sample_t s;
        s.volt_alpha = va;
        s.volt_beta  = vb;
        s.curr_alpha = ia;
        s.curr_beta  = ib;
        return s;
    endfunction

    function automatic logic [15:0] random_level();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_gain();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 8192));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] nudge(input logic signed [15:0] v);
        int n;
        n = int'(v) + int'($urandom_range(0, 600)) - 300;
        if (n > 32767) begin
            n = 32767;
        end else if (n < -32768) begin
            n = -32768;
        end
        return 16'(n);
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            flag_error($sformatf("%s mismatch: expected %0d, got %0d",
                                 name, $signed(exp_v), $signed(act_v)));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_word = o_m_axis_tdata;
            if (expected_words.size() == 0) begin
                flag_error($sformatf("unexpected output word %h", got_word));
            end else begin
                compare_field("rotor_angle", expected_words[0].rotor_angle, got_word.rotor_angle);
                compare_field("emf_alpha", expected_words[0].emf_alpha, got_word.emf_alpha);
                compare_field("emf_beta", expected_words[0].emf_beta, got_word.emf_beta);
                void'(expected_words.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                sink_hold <= pick_gap();
            end
        end
    end

    task automatic send_sample(input stator_sample_t s);
        i_s_axis_tdata  <= s;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_words.push_back(predict_observer_word(s));
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DECAY: decay_gain = val;
            CFG_INPUT: input_gain = val;
            CFG_LIMIT: err_limit  = val[LIM_W-1:0];
            CFG_SLIDE: slide_k    = val;
            CFG_EMF:   filter_k   = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] decay, input logic [15:0] gain_in,
                                input logic [15:0] limit, input logic [15:0] slide,
                                input logic [15:0] filter);
        wait_idle();
        write_reg(CFG_DECAY, decay);
        write_reg(CFG_INPUT, gain_in);
        write_reg(CFG_LIMIT, limit);
        write_reg(CFG_SLIDE, slide);
        write_reg(CFG_EMF, filter);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_sample(make_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_sample(make_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    endtask

    task automatic test_register_extremes();
        // The limit word has its top bit set, which the register drops.
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_sample(make_sample(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF));
    endtask

    task automatic test_zero_gains();
        apply_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(make_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
        send_sample(make_sample(16'h1234, 16'hEDCB, 16'h0FFF, 16'hF001));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_spare_indices();
        apply_config(16'd4000, 16'd300, 16'd2048, 16'd500, 16'd200);
        @(posedge i_clk);
        for (int idx = FIRST_SPARE_IDX; idx < 2 ** CFG_IDX_W; idx++) begin
            write_reg(CFG_IDX_W'(idx), (idx == FIRST_SPARE_IDX) ? 16'hFFFF : 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
        send_sample(make_sample(16'h0800, 16'hF800, 16'h0100, 16'hFF00));
        send_sample(make_sample(16'hF000, 16'h1000, 16'h0000, 16'h0400));
    endtask

    task automatic test_angle_quadrants();
        // With no plant model, unit slide scaling and a transparent filter,
        // each back EMF component is the negated measured current.
        apply_config(16'h0000, 16'h0000, 16'h7FFF, 16'd2048, 16'd4096);
        send_sample(make_sample(16'($urandom), 16'($urandom), 16'h0000, 16'h0000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'hF000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h1000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'hF000, 16'h0000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h1000, 16'h0000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h8000, 16'h8000));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h8000, 16'h7FFF));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0300, 16'h8000));
    endtask

    task automatic test_random_observer();
        stator_sample_t s;
        for (int phase = 0; phase < 8; phase++) begin
            gaps_on   = (phase != 3);
            stalls_on = (phase != 3) && (phase != 6);
            if (phase % 2 == 0) begin
                apply_config(16'($urandom_range(3800, 4096)), 16'($urandom_range(50, 600)),
                             16'($urandom_range(256, 8192)), 16'($urandom_range(20, 4000)),
                             16'($urandom_range(20, 1500)));
            end else if (phase == 5) begin
                apply_config(16'h0000, 16'h0000, 16'h7FFF, 16'd2048, 16'd4096);
            end else begin
                apply_config(random_gain(), random_gain(), random_gain(), random_gain(),
                             random_gain());
            end
            walk = make_sample(random_level(), random_level(), random_level(), random_level());
            for (int n = 0; n < 65; n++) begin
                if (phase % 2 == 0 && $urandom_range(0, 19) != 0) begin
                    walk = make_sample(nudge(walk.volt_alpha), nudge(walk.volt_beta),
                                       nudge(walk.curr_alpha), nudge(walk.curr_beta));
                    s = walk;
                end else begin
                    s = make_sample(random_level(), random_level(), random_level(),
                                    random_level());
                end
                send_sample(s);
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_DECAY;
        i_cfg_data      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_zero_gains();
        test_spare_indices();
        test_angle_quadrants();
        test_random_observer();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
